[rtl/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants for the quadratic root solver: status codes, case
// codes and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int ROOT_W   = 34;
	localparam int STATUS_W = 3;
	localparam int KIND_W   = 3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ANY    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ONE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TWO    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOREAL = 3'd4;

	// equation kind, decided from which coefficients are zero
	localparam logic [KIND_W-1:0] KD_ANY   = 3'd0;  // all zero
	localparam logic [KIND_W-1:0] KD_NONE  = 3'd1;  // only c nonzero
	localparam logic [KIND_W-1:0] KD_LIN   = 3'd2;  // a zero, b nonzero
	localparam logic [KIND_W-1:0] KD_CZERO = 3'd3;  // a, b nonzero, c zero
	localparam logic [KIND_W-1:0] KD_FULL  = 3'd4;  // a nonzero, c nonzero or b zero

endpackage

[rtl/qrs_coef_if.sv]
// ----------------------------------------------------------------------------
// qrs_coef_if
// Coefficient channel: valid/ready handshake with coefficients a, b, c.
// ----------------------------------------------------------------------------
interface qrs_coef_if #(parameter int CW = 16);

	logic          valid;
	logic          ready;
	logic [CW-1:0] coef_a;
	logic [CW-1:0] coef_b;
	logic [CW-1:0] coef_c;

	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);

endinterface

[rtl/qrs_root_if.sv]
// ----------------------------------------------------------------------------
// qrs_root_if
// Result channel: valid/ready handshake with status and two fixed-point roots.
// ----------------------------------------------------------------------------
interface qrs_root_if;

	logic                               valid;
	logic                               ready;
	logic [qrs_pkg::STATUS_W-1:0]       status;
	logic signed [qrs_pkg::ROOT_W-1:0]  root_first;
	logic signed [qrs_pkg::ROOT_W-1:0]  root_second;

	modport source (output valid, output status, output root_first, output root_second,
		input ready);
	modport sink   (input valid, input status, input root_first, input root_second,
		output ready);

endinterface

[rtl/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage (digit by digit,
// restoring). Gives floor(sqrt(rad)) after RW stages; side data rides along.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
	parameter int RW = 33,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	logic            v_s    [0:RW];
	logic [2*RW-1:0] x_s    [0:RW];
	logic [RW:0]     rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];
	logic [SW-1:0]   side_s [0:RW];

	// stage zero is the input itself
	assign v_s[0]    = in_valid;
	assign x_s[0]    = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+2:0] rs;
		logic [RW+2:0] trial;
		logic [RW+2:0] rn;
		logic          ge;

		// bring down two radicand bits, try root*4+1
		always_comb begin
			rs    = {rem_s[i], x_s[i][2*RW-1 -: 2]};
			trial = {1'b0, root_s[i], 2'b01};
			ge    = (rs >= trial);
			rn    = ge ? (rs - trial) : rs;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]    <= {x_s[i][2*RW-3:0], 2'b00};
				rem_s[i+1]  <= rn[RW:0];
				root_s[i+1] <= {root_s[i][RW-2:0], ge};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];

endmodule

[rtl/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage. Two
// numerators share one divisor; floor quotients come out after NW stages.
// ----------------------------------------------------------------------------
module qrs_div #(
	parameter int NW = 34,
	parameter int DW = 17,
	parameter int SW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num1,
	input  logic [NW-1:0] num2,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo1,
	output logic [NW-1:0] quo2,
	output logic [SW-1:0] side_out
);

	logic          v_s  [0:NW];
	logic [NW-1:0] n1_s [0:NW];
	logic [NW-1:0] n2_s [0:NW];
	logic [DW-1:0] r1_s [0:NW];
	logic [DW-1:0] r2_s [0:NW];
	logic [NW-1:0] q1_s [0:NW];
	logic [NW-1:0] q2_s [0:NW];
	logic [DW-1:0] d_s  [0:NW];
	logic [SW-1:0] sd_s [0:NW];

	assign v_s[0]  = in_valid;
	assign n1_s[0] = num1;
	assign n2_s[0] = num2;
	assign r1_s[0] = '0;
	assign r2_s[0] = '0;
	assign q1_s[0] = '0;
	assign q2_s[0] = '0;
	assign d_s[0]  = den;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] rs1, rs2, rn1, rn2;
		logic        ge1, ge2;

		// shift in next numerator bit, subtract divisor if it fits
		always_comb begin
			rs1 = {r1_s[i], n1_s[i][NW-1]};
			rs2 = {r2_s[i], n2_s[i][NW-1]};
			ge1 = (rs1 >= {1'b0, d_s[i]});
			ge2 = (rs2 >= {1'b0, d_s[i]});
			rn1 = ge1 ? (rs1 - {1'b0, d_s[i]}) : rs1;
			rn2 = ge2 ? (rs2 - {1'b0, d_s[i]}) : rs2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n1_s[i+1] <= {n1_s[i][NW-2:0], 1'b0};
				n2_s[i+1] <= {n2_s[i][NW-2:0], 1'b0};
				r1_s[i+1] <= rn1[DW-1:0];
				r2_s[i+1] <= rn2[DW-1:0];
				q1_s[i+1] <= {q1_s[i][NW-2:0], ge1};
				q2_s[i+1] <= {q2_s[i][NW-2:0], ge2};
				d_s[i+1]  <= d_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quo1      = q1_s[NW];
	assign quo2      = q2_s[NW];
	assign side_out  = sd_s[NW];

endmodule

[rtl/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, fully pipelined.
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------
//   coefs   | in  | coef_a, coef_b, coef_c (two's complement)
//   roots   | out | status, root_first, root_second (FRAC_BITS frac)
//
// One beat is taken every cycle while the skid is empty. The pipeline has
// two product/discriminant stages, one square-root stage per root bit, one
// numerator stage, one divider stage per quotient bit, a sign/saturate stage
// and the output register. A two-entry output (register plus skid) keeps
// input ready a registered signal; the pipeline freezes only once the skid
// is full. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qrs_coef_if.sink   coefs,
	qrs_root_if.source roots
);

	localparam int CW   = COEF_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int PW   = 2 * CW;            // product width
	localparam int DW   = 2 * CW + 2;        // signed discriminant width
	localparam int SQW  = CW + F + 1;        // square root width
	localparam int RADW = 2 * SQW;           // radicand width
	localparam int NW   = CW + F + 2;        // numerator magnitude width
	localparam int NSW  = NW + 1;            // signed numerator width
	localparam int DNW  = CW + 1;            // divisor magnitude width
	localparam int DSW  = CW + 2;            // signed divisor width
	localparam int RW   = qrs_pkg::ROOT_W;
	localparam int XW   = (NSW > RW) ? NSW : RW + 1;
	localparam logic signed [XW-1:0] RMAX = XW'((64'sd1 <<< (RW - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] RMIN = -RMAX - XW'(1);

	typedef struct packed {
		logic signed [CW-1:0]             a;
		logic signed [CW-1:0]             b;
		logic signed [CW-1:0]             c;
		logic [qrs_pkg::KIND_W-1:0]       kind;
		logic                             bzero;
		logic                             dpos;
		logic [qrs_pkg::STATUS_W-1:0]     status;
	} sq_side_t;

	typedef struct packed {
		logic [qrs_pkg::STATUS_W-1:0] status;
		logic                         neg1;
		logic                         neg2;
	} dv_side_t;

	// flow control
	logic en, acc, take;
	logic o_v_q, sk_v_q;

	assign en          = !sk_v_q;
	assign coefs.ready = en;
	assign acc         = coefs.valid && en;
	assign take        = o_v_q && roots.ready;

	// ---------------- stage 1: products ----------------
	logic signed [CW-1:0] a_in, b_in, c_in;
	logic                 v_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;
	logic signed [PW-1:0] bb_s1, ac_s1;

	assign a_in = $signed(coefs.coef_a[CW-1:0]);
	assign b_in = $signed(coefs.coef_b[CW-1:0]);
	assign c_in = $signed(coefs.coef_c[CW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a_in;
			b_s1  <= b_in;
			c_s1  <= c_in;
			bb_s1 <= PW'(b_in) * PW'(b_in);
			ac_s1 <= PW'(a_in) * PW'(c_in);
		end
	end

	// ---------------- stage 2: discriminant and kind ----------------
	logic [qrs_pkg::KIND_W-1:0] kind_c;
	logic                       v_s2;
	logic signed [CW-1:0]       a_s2, b_s2, c_s2;
	logic signed [DW-1:0]       d_s2;
	logic [qrs_pkg::KIND_W-1:0] kind_s2;

	always_comb begin
		if (a_s1 == '0) begin
			if (b_s1 == '0) begin
				kind_c = (c_s1 == '0) ? qrs_pkg::KD_ANY : qrs_pkg::KD_NONE;
			end else begin
				kind_c = qrs_pkg::KD_LIN;
			end
		end else if (c_s1 == '0 && b_s1 != '0) begin
			kind_c = qrs_pkg::KD_CZERO;
		end else begin
			kind_c = qrs_pkg::KD_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			d_s2    <= DW'(bb_s1) - (DW'(ac_s1) <<< 2);
			kind_s2 <= kind_c;
		end
	end

	// ---------------- square root of D scaled by 4^F ----------------
	sq_side_t        sq_in, sq_out;
	logic [RADW-1:0] rad;
	logic            sq_v;
	logic [SQW-1:0]  sq_root;
	logic            dpos, dzero;

	always_comb begin
		dpos          = (d_s2 > DW'(0));
		dzero         = (d_s2 == '0);
		sq_in.a       = a_s2;
		sq_in.b       = b_s2;
		sq_in.c       = c_s2;
		sq_in.kind    = kind_s2;
		sq_in.bzero   = (b_s2 == '0);
		sq_in.dpos    = dpos;
		case (kind_s2)
			qrs_pkg::KD_ANY:   sq_in.status = qrs_pkg::ST_ANY;
			qrs_pkg::KD_NONE:  sq_in.status = qrs_pkg::ST_NONE;
			qrs_pkg::KD_LIN:   sq_in.status = qrs_pkg::ST_ONE;
			qrs_pkg::KD_CZERO: sq_in.status = qrs_pkg::ST_TWO;
			default: begin
				if (dpos) begin
					sq_in.status = qrs_pkg::ST_TWO;
				end else if (dzero) begin
					sq_in.status = qrs_pkg::ST_ONE;
				end else begin
					sq_in.status = qrs_pkg::ST_NOREAL;
				end
			end
		endcase
		rad = (kind_s2 == qrs_pkg::KD_FULL && dpos) ?
			(RADW'($unsigned(d_s2)) << (2 * F)) : '0;
	end

	qrs_sqrt #(
		.RW (SQW),
		.SW ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.rad       (rad),
		.side_in   (sq_in),
		.out_valid (sq_v),
		.root      (sq_root),
		.side_out  (sq_out)
	);

	// ---------------- stage 3: numerators and divisor ----------------
	logic signed [NSW-1:0] nb, cn, s_x, n1, n2;
	logic signed [DSW-1:0] dn, a2;
	logic signed [NSW-1:0] m1, m2;
	logic signed [DSW-1:0] dm;
	dv_side_t              dv_in;
	logic                  v_s3;
	logic [NW-1:0]         n1m_s3, n2m_s3;
	logic [DNW-1:0]        dm_s3;
	dv_side_t              side_s3;

	always_comb begin
		nb  = -(NSW'(sq_out.b) <<< F);
		cn  = -(NSW'(sq_out.c) <<< F);
		s_x = $signed(NSW'(sq_root));
		a2  = DSW'(sq_out.a) <<< 1;
		case (sq_out.kind)
			qrs_pkg::KD_LIN: begin
				n1 = cn;
				n2 = '0;
				dn = DSW'(sq_out.b);
			end
			qrs_pkg::KD_CZERO: begin
				n1 = '0;
				n2 = nb <<< 1;
				dn = a2;
			end
			qrs_pkg::KD_FULL: begin
				if (sq_out.bzero) begin
					// +-sqrt(-c/a): positive root first
					n1 = s_x;
					n2 = -s_x;
					dn = a2[DSW-1] ? -a2 : a2;
				end else if (sq_out.dpos) begin
					n1 = nb + s_x;
					n2 = nb - s_x;
					dn = a2;
				end else if (sq_out.status == qrs_pkg::ST_ONE) begin
					n1 = nb;
					n2 = '0;
					dn = a2;
				end else begin
					n1 = '0;
					n2 = '0;
					dn = a2;
				end
			end
			default: begin
				n1 = '0;
				n2 = '0;
				dn = DSW'(1);
			end
		endcase
		m1            = n1[NSW-1] ? -n1 : n1;
		m2            = n2[NSW-1] ? -n2 : n2;
		dm            = dn[DSW-1] ? -dn : dn;
		dv_in.status  = sq_out.status;
		dv_in.neg1    = n1[NSW-1] ^ dn[DSW-1];
		dv_in.neg2    = n2[NSW-1] ^ dn[DSW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1m_s3  <= m1[NW-1:0];
			n2m_s3  <= m2[NW-1:0];
			dm_s3   <= dm[DNW-1:0];
			side_s3 <= dv_in;
		end
	end

	// ---------------- truncating division ----------------
	logic          dv_v;
	logic [NW-1:0] q1, q2;
	dv_side_t      dv_out;

	qrs_div #(
		.NW (NW),
		.DW (DNW),
		.SW ($bits(dv_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num1      (n1m_s3),
		.num2      (n2m_s3),
		.den       (dm_s3),
		.side_in   (side_s3),
		.out_valid (dv_v),
		.quo1      (q1),
		.quo2      (q2),
		.side_out  (dv_out)
	);

	// ---------------- stage 4: sign and saturate ----------------
	logic signed [XW-1:0]                x1, x2;
	logic signed [RW-1:0]                r1_c, r2_c;
	logic                                v_s4;
	logic [qrs_pkg::STATUS_W-1:0]        st_s4;
	logic signed [RW-1:0]                r1_s4, r2_s4;

	always_comb begin
		x1 = dv_out.neg1 ? -$signed(XW'(q1)) : $signed(XW'(q1));
		x2 = dv_out.neg2 ? -$signed(XW'(q2)) : $signed(XW'(q2));
		if (x1 > RMAX) begin
			r1_c = RMAX[RW-1:0];
		end else if (x1 < RMIN) begin
			r1_c = RMIN[RW-1:0];
		end else begin
			r1_c = x1[RW-1:0];
		end
		if (x2 > RMAX) begin
			r2_c = RMAX[RW-1:0];
		end else if (x2 < RMIN) begin
			r2_c = RMIN[RW-1:0];
		end else begin
			r2_c = x2[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= dv_out.status;
			r1_s4 <= r1_c;
			r2_s4 <= r2_c;
		end
	end

	// ---------------- output register and skid ----------------
	logic [qrs_pkg::STATUS_W-1:0] o_st_q, sk_st_q;
	logic signed [RW-1:0]         o_r1_q, o_r2_q, sk_r1_q, sk_r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!sk_v_q) begin
			if (!o_v_q || take) begin
				o_v_q <= v_s4;
			end else if (v_s4) begin
				sk_v_q <= 1'b1;
			end
		end else if (take) begin
			o_v_q  <= 1'b1;
			sk_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_v_q) begin
			if (!o_v_q || take) begin
				o_st_q <= st_s4;
				o_r1_q <= r1_s4;
				o_r2_q <= r2_s4;
			end else begin
				sk_st_q <= st_s4;
				sk_r1_q <= r1_s4;
				sk_r2_q <= r2_s4;
			end
		end else if (take) begin
			o_st_q <= sk_st_q;
			o_r1_q <= sk_r1_q;
			o_r2_q <= sk_r2_q;
		end
	end

	assign roots.valid       = o_v_q;
	assign roots.status      = o_st_q;
	assign roots.root_first  = o_r1_q;
	assign roots.root_second = o_r2_q;

	// ---------------- checks ----------------
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(o_v_q && !roots.ready))
		else $error("skid filled while output was free");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid holds a beat but output register is empty");

	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && (o_st_q == qrs_pkg::ST_ANY || o_st_q == qrs_pkg::ST_NONE ||
			o_st_q == qrs_pkg::ST_NOREAL)) |-> (o_r1_q == '0 && o_r2_q == '0))
		else $error("nonzero root with a rootless status");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for quadratic_root_solver. Coefficient beats come from a
// directed table, then from random sets biased toward the special cases.
// Each result is compared against a typed answer or a behavioral root predictor.
// ----------------------------------------------------------------------------
module tb;

	localparam int CW        = 16;
	localparam int FB        = 16;
	localparam int N_RANDOM  = 1800;
	localparam int LATENCY   = 2*CW + 2*FB + 8;

	typedef struct {
		logic [qrs_pkg::STATUS_W-1:0]      status;
		logic signed [qrs_pkg::ROOT_W-1:0] root_first;
		logic signed [qrs_pkg::ROOT_W-1:0] root_second;
	} roots_t;

	typedef struct {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		bit                   typed;
		roots_t               want;
	} coef_row_t;

	logic clk;
	logic arst_n;

	qrs_coef_if #(.CW(CW)) coefs ();
	qrs_root_if            roots ();

	quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coefs  (coefs),
		.roots  (roots)
	);

	roots_t    pending_roots[$];
	coef_row_t coef_table[$];
	int        n_errors;
	int        n_sent;
	int        n_checked;
	bit        hold_off;
	bit        stim_done;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// floor of the square root of a 128-bit value below 2^66
	function automatic longint floor_sqrt(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int k = 32; k >= 0; k--) begin
			t = r | (64'd1 << k);
			if (128'(t) * 128'(t) <= v)
				r = t;
		end
		return longint'(r);
	endfunction

	// saturation of a signed value to the root width
	function automatic logic signed [qrs_pkg::ROOT_W-1:0] sat_root(input longint v);
		longint hi;
		hi = (longint'(1) <<< (qrs_pkg::ROOT_W-1)) - 1;
		if (v > hi)
			return hi[qrs_pkg::ROOT_W-1:0];
		if (v < -hi - 1)
			return qrs_pkg::ROOT_W'(-hi - 1);
		return v[qrs_pkg::ROOT_W-1:0];
	endfunction

	// expected roots for one coefficient set
	function automatic roots_t solve_roots(input logic signed [CW-1:0] ca,
		input logic signed [CW-1:0] cb, input logic signed [CW-1:0] cc);
		longint a, b, c, d, nb, r1, r2, s;
		logic [63:0] q;
		roots_t res;
		a = ca; b = cb; c = cc;
		r1 = 0; r2 = 0;
		if (a == 0) begin
			if (b == 0) begin
				res.status = (c == 0) ? qrs_pkg::ST_ANY : qrs_pkg::ST_NONE;
			end else begin
				res.status = qrs_pkg::ST_ONE;
				if (c != 0)
					r1 = (-c * (longint'(1) <<< FB)) / b;
			end
		end else if (b == 0) begin
			if (c == 0) begin
				res.status = qrs_pkg::ST_ONE;
			end else if ((c < 0) == (a < 0)) begin
				res.status = qrs_pkg::ST_NOREAL;
			end else begin
				q = ((c < 0 ? -c : c) <<< (2*FB)) / (a < 0 ? -a : a);
				s = floor_sqrt(128'(q));
				res.status = qrs_pkg::ST_TWO;
				r1 = s;
				r2 = -s;
			end
		end else if (c == 0) begin
			res.status = qrs_pkg::ST_TWO;
			r2 = (-b * (longint'(1) <<< FB)) / a;
		end else begin
			d = b*b - 4*a*c;
			nb = -b * (longint'(1) <<< FB);
			if (d > 0) begin
				s = floor_sqrt(128'(d) << (2*FB));
				res.status = qrs_pkg::ST_TWO;
				r1 = (nb + s) / (2*a);
				r2 = (nb - s) / (2*a);
			end else if (d == 0) begin
				res.status = qrs_pkg::ST_ONE;
				r1 = nb / (2*a);
			end else begin
				res.status = qrs_pkg::ST_NOREAL;
			end
		end
		res.root_first  = sat_root(r1);
		res.root_second = sat_root(r2);
		return res;
	endfunction

	function automatic roots_t mk_roots(input logic [qrs_pkg::STATUS_W-1:0] st,
		input longint r1, input longint r2);
		roots_t r;
		r.status = st;
		r.root_first = r1[qrs_pkg::ROOT_W-1:0];
		r.root_second = r2[qrs_pkg::ROOT_W-1:0];
		return r;
	endfunction

	function automatic coef_row_t mk_row(input int a, input int b, input int c,
		input bit typed, input roots_t want);
		coef_row_t row;
		row.a = a[CW-1:0];
		row.b = b[CW-1:0];
		row.c = c[CW-1:0];
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	// random coefficient, often small or extreme
	function automatic int pick_coef();
		case ($urandom_range(0, 5))
			0: return 0;
			1, 2: return $signed($urandom_range(0, 16)) - 8;
			3: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $signed($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// directed rows: typed where the answer is obvious
	task automatic build_table();
		roots_t z;
		z = mk_roots(qrs_pkg::ST_ANY, 0, 0);
		coef_table.push_back(mk_row(0, 0, 0, 1, mk_roots(qrs_pkg::ST_ANY, 0, 0)));
		coef_table.push_back(mk_row(0, 0, 5, 1, mk_roots(qrs_pkg::ST_NONE, 0, 0)));
		coef_table.push_back(mk_row(0, 0, -32768, 1, mk_roots(qrs_pkg::ST_NONE, 0, 0)));
		coef_table.push_back(mk_row(0, 7, 0, 1, mk_roots(qrs_pkg::ST_ONE, 0, 0)));
		coef_table.push_back(mk_row(0, 2, -4, 1, mk_roots(qrs_pkg::ST_ONE, 2 <<< FB, 0)));
		coef_table.push_back(mk_row(0, -1, -32768, 1,
			mk_roots(qrs_pkg::ST_ONE, -32768 <<< FB, 0)));
		coef_table.push_back(mk_row(0, 32767, 32767, 0, z));
		coef_table.push_back(mk_row(3, 0, 0, 1, mk_roots(qrs_pkg::ST_ONE, 0, 0)));
		coef_table.push_back(mk_row(1, 0, 4, 1, mk_roots(qrs_pkg::ST_NOREAL, 0, 0)));
		coef_table.push_back(mk_row(1, 0, -4, 1,
			mk_roots(qrs_pkg::ST_TWO, 2 <<< FB, -(2 <<< FB))));
		coef_table.push_back(mk_row(-1, 0, 32767, 0, z));
		coef_table.push_back(mk_row(1, 0, -32768, 0, z));
		coef_table.push_back(mk_row(-32768, 0, 32767, 0, z));
		coef_table.push_back(mk_row(1, -6, 0, 1, mk_roots(qrs_pkg::ST_TWO, 0, 6 <<< FB)));
		coef_table.push_back(mk_row(-32768, -32768, 0, 0, z));
		coef_table.push_back(mk_row(1, -3, 2, 1,
			mk_roots(qrs_pkg::ST_TWO, 2 <<< FB, 1 <<< FB)));
		coef_table.push_back(mk_row(1, 2, 1, 1,
			mk_roots(qrs_pkg::ST_ONE, -(1 <<< FB), 0)));
		coef_table.push_back(mk_row(1, 1, 1, 1, mk_roots(qrs_pkg::ST_NOREAL, 0, 0)));
		coef_table.push_back(mk_row(1, -32768, -32768, 0, z));
		coef_table.push_back(mk_row(-32768, 32767, 32767, 0, z));
		coef_table.push_back(mk_row(32767, -32768, 32767, 0, z));
		coef_table.push_back(mk_row(-1, -1, -1, 0, z));
		coef_table.push_back(mk_row(-32768, -32768, -32768, 0, z));
		coef_table.push_back(mk_row(3, 7, -5, 0, z));
	endtask

	// send one coefficient beat, waiting for acceptance
	task automatic send_beat(input coef_row_t row);
		coefs.valid  <= 1'b1;
		coefs.coef_a <= row.a;
		coefs.coef_b <= row.b;
		coefs.coef_c <= row.c;
		pending_roots.push_back(row.typed ? row.want : solve_roots(row.a, row.b, row.c));
		do @(posedge clk); while (!coefs.ready);
		n_sent++;
	endtask

	// sender idles between bursts
	task automatic idle_gap(input int n);
		coefs.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stimulus
	initial begin
		coef_row_t row;
		int burst;
		coefs.valid  <= 1'b0;
		coefs.coef_a <= '0;
		coefs.coef_b <= '0;
		coefs.coef_c <= '0;
		n_errors = 0; n_sent = 0; n_checked = 0; stim_done = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_table();
		foreach (coef_table[i]) begin
			send_beat(coef_table[i]);
			if ($urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 3));
		end
		for (int i = 0; i < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
				row = mk_row(pick_coef(), pick_coef(), pick_coef(), 0, row.want);
				send_beat(row);
			end
			if ($urandom_range(0, 2) != 0)
				idle_gap($urandom_range(1, 6));
		end
		coefs.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int cyc;
		roots.ready <= 1'b0;
		hold_off = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			hold_off = (cyc >= 400 && cyc < 700);
			if (hold_off)
				roots.ready <= 1'b0;
			else if ((cyc / 256) % 3 == 0)
				roots.ready <= 1'b1;
			else
				roots.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		roots_t want;
		if (arst_n && roots.valid && roots.ready) begin
			if (pending_roots.size() == 0) begin
				$error("unexpected result beat: status %0d", roots.status);
				n_errors++;
			end else begin
				want = pending_roots.pop_front();
				n_checked++;
				if (roots.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, roots.status);
					n_errors++;
				end
				if (roots.root_first !== want.root_first) begin
					$error("root_first: expected %0d, actual %0d",
						want.root_first, roots.root_first);
					n_errors++;
				end
				if (roots.root_second !== want.root_second) begin
					$error("root_second: expected %0d, actual %0d",
						want.root_second, roots.root_second);
					n_errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (pending_roots.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d coefficient sets, %0d results checked, incl. a long output stall.",
			n_sent, n_checked);
		if (n_errors == 0 && pending_roots.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/qrs_pkg.sv
rtl/qrs_coef_if.sv
rtl/qrs_root_if.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
tb/sv/tb.sv
